### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the attitude mixer.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent on this edge implies consequent on the same edge.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition must never hold while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`endif

### hw/rtl/qapm_pkg.sv
// Types, constants and table builder for the quaternion attitude mixer.
// No dependencies.
package qapm_pkg;

    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] REG_P_GAIN   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_D_GAIN   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ARM_THR  = 2'd2;
    localparam logic [9:0] ARM_THR_RESET = 10'd37;

    localparam longint HalfPiQ16 = 102944;
    localparam longint PiQ16 = 205887;
    localparam int CordicSteps = 16;
    localparam longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2};

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [9:0]         throttle;
    } cmd_t;

    typedef struct packed {
        logic [10:0] motor_0;
        logic [10:0] motor_1;
        logic [10:0] motor_2;
        logic [10:0] motor_3;
        logic        active;
    } result_t;

    // Shift-subtract unsigned division, used only while building the table.
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (b > v)
                b = b >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Entry k of the acos(w)/sqrt(1-w^2) table, unsigned Q4.12.
    function automatic logic [15:0] scale_entry(int k, int depth);
        longint w;
        longint wa;
        longint s;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint theta;
        logic [63:0] q;
        w = -(longint'(1) <<< 30)
            + longint'(udiv64(64'(k) << 31, 64'(depth - 1)));
        if (w > (longint'(1) <<< 30))
            w = longint'(1) <<< 30;
        wa = (w < 0) ? -w : w;
        s = longint'(isqrt64((64'd1 << 60) - 64'(wa * wa)));
        if (s == 0)
            return (w > 0) ? 16'd4096 : 16'hFFFF;
        x = s;
        y = w;
        z = 0;
        for (int i = 0; i < CordicSteps; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q16[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q16[i];
            end
        end
        theta = HalfPiQ16 - z;
        if (theta < 0)
            theta = 0;
        if (theta > PiQ16)
            theta = PiQ16;
        q = udiv64((64'(theta) << 26) + (64'(s) >> 1), 64'(s));
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

endpackage

### hw/rtl/quad_attitude_pd_mixer_core.sv
// Done is the stage-five valid bit and the result is the stage-five register, so the
// result is valid while done is high. Throughput: one item per cycle; busy is always
// low, five pipeline stages. The scale lookup is a ROM read with a registered output
// in stage two. Reset (rst_n low, asynchronous) clears the stage valid bits and sets
// p_gain = 0, d_gain = 0, arm_threshold = 37. Results cannot be stalled.
module quad_attitude_pd_mixer_core #(
    parameter int SCALE_TABLE_DEPTH = 1024,
    parameter int YAW_DIRECTION = -1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  qapm_pkg::cmd_t                    cmd,
    output logic                              done,
    output qapm_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qapm_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [15:0]                       cfg_data
);
    import qapm_pkg::*;
    `include "assert_macros.svh"

    localparam int IdxW = $clog2(SCALE_TABLE_DEPTH);
    localparam int ProdW = 17 + IdxW + 1;
    localparam logic [ProdW-1:0] DenK = ProdW'(SCALE_TABLE_DEPTH - 1);
    localparam logic [ProdW-1:0] MaxIdx = ProdW'(SCALE_TABLE_DEPTH - 1);

    // Configuration registers.
    logic [15:0] p_gain_reg;
    logic [15:0] d_gain_reg;
    logic [9:0]  arm_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_reg  <= '0;
            d_gain_reg  <= '0;
            arm_thr_reg <= ARM_THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_P_GAIN:  p_gain_reg  <= cfg_data;
                REG_D_GAIN:  d_gain_reg  <= cfg_data;
                REG_ARM_THR: arm_thr_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy = 1'b0;

    // X-mix of a vector (a, b, c) for one motor.
    function automatic logic signed [17:0] mix(int m, logic signed [15:0] a,
                                               logic signed [15:0] b,
                                               logic signed [15:0] c);
        logic signed [17:0] ea;
        logic signed [17:0] eb;
        logic signed [17:0] yc;
        ea = 18'(a);
        eb = 18'(b);
        yc = (YAW_DIRECTION > 0) ? 18'(c) : (YAW_DIRECTION < 0) ? -18'(c) : 18'sd0;
        case (m)
            0: return -ea + eb - yc;
            1: return ea + eb + yc;
            2: return ea - eb - yc;
            default: return -ea - eb + yc;
        endcase
    endfunction

    // Stage 1: table index, arm decision, vector mixes.
    logic                   v1_reg;
    logic [IdxW-1:0]        idx1_reg;
    logic                   arm1_reg;
    logic [9:0]             thr1_reg;
    logic signed [17:0]     mq1_reg [4];
    logic signed [17:0]     mr1_reg [4];
    logic [ProdW-1:0]       idx_prod;
    logic [ProdW-1:0]       idx_sh;

    assign idx_prod = ProdW'({~cmd.quat_w[15], cmd.quat_w[14:0]}) * DenK
                      + ProdW'(32768);
    assign idx_sh = idx_prod >> 16;

    always_ff @(posedge clk)
    begin
        idx1_reg <= (idx_sh > MaxIdx) ? MaxIdx[IdxW-1:0] : idx_sh[IdxW-1:0];
        arm1_reg <= cmd.throttle > arm_thr_reg;
        thr1_reg <= cmd.throttle;
        for (int m = 0; m < 4; m++)
        begin
            mq1_reg[m] <= mix(m, cmd.quat_x, cmd.quat_y, cmd.quat_z);
            mr1_reg[m] <= mix(m, cmd.rate_x, cmd.rate_y, cmd.rate_z);
        end
    end

    // Stage 2: scale lookup and rate times D gain.
    logic                   v2_reg;
    logic                   arm2_reg;
    logic [9:0]             thr2_reg;
    logic signed [17:0]     mq2_reg [4];
    logic signed [34:0]     dp2_reg [4];
    logic [15:0]            scale2;

    qapm_scale_rom #(.DEPTH(SCALE_TABLE_DEPTH)) u_rom (
        .clk  (clk),
        .addr (idx1_reg),
        .data (scale2)
    );

    always_ff @(posedge clk)
    begin
        arm2_reg <= arm1_reg;
        thr2_reg <= thr1_reg;
        for (int m = 0; m < 4; m++)
        begin
            mq2_reg[m] <= mq1_reg[m];
            dp2_reg[m] <= 35'(mr1_reg[m]) * 35'($signed({1'b0, d_gain_reg}));
        end
    end

    // Stage 3: scale times P gain, D term truncated and saturated.
    logic                   v3_reg;
    logic                   arm3_reg;
    logic [9:0]             thr3_reg;
    logic signed [17:0]     mq3_reg [4];
    logic signed [15:0]     dt3_reg [4];
    logic [31:0]            sp3_reg;
    logic signed [34:0]     dp_adj [4];
    logic signed [18:0]     dp_q [4];

    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            dp_adj[m] = dp2_reg[m] + (dp2_reg[m][34] ? 35'sd65535 : 35'sd0);
            dp_q[m] = 19'(dp_adj[m] >>> 16);
        end
    end

    always_ff @(posedge clk)
    begin
        arm3_reg <= arm2_reg;
        thr3_reg <= thr2_reg;
        sp3_reg  <= 32'(scale2) * 32'(p_gain_reg);
        for (int m = 0; m < 4; m++)
        begin
            mq3_reg[m] <= mq2_reg[m];
            dt3_reg[m] <= (dp_q[m] > 19'sd32767) ? 16'sd32767 :
                          (dp_q[m] < -19'sd32768) ? -16'sd32768 : 16'(dp_q[m]);
        end
    end

    // Stage 4: mixed quaternion vector times scale times P gain.
    logic                   v4_reg;
    logic                   arm4_reg;
    logic [9:0]             thr4_reg;
    logic signed [15:0]     dt4_reg [4];
    logic signed [50:0]     pp4_reg [4];

    always_ff @(posedge clk)
    begin
        arm4_reg <= arm3_reg;
        thr4_reg <= thr3_reg;
        for (int m = 0; m < 4; m++)
        begin
            dt4_reg[m] <= dt3_reg[m];
            pp4_reg[m] <= 51'(mq3_reg[m]) * 51'($signed({1'b0, sp3_reg}));
        end
    end

    // Stage 5: P term, sum, throttle offset and clip.
    logic                   v5_reg;
    result_t                res_reg;
    result_t                res_next;
    logic signed [50:0]     pp_adj [4];
    logic signed [17:0]     pp_q [4];
    logic signed [15:0]     pt [4];
    logic signed [16:0]     sum17 [4];
    logic signed [15:0]     sum16 [4];
    logic signed [17:0]     mv [4];
    logic signed [17:0]     lim;
    logic [10:0]            mot [4];

    always_comb
    begin
        lim = 18'(thr4_reg) + 18'(thr4_reg >> 1);
        for (int m = 0; m < 4; m++)
        begin
            pp_adj[m] = pp4_reg[m] + (pp4_reg[m][50] ? 51'sh1_FFFF_FFFF : 51'sd0);
            pp_q[m] = 18'(pp_adj[m] >>> 33);
            pt[m] = (pp_q[m] > 18'sd32767) ? 16'sd32767 :
                    (pp_q[m] < -18'sd32768) ? -16'sd32768 : 16'(pp_q[m]);
            sum17[m] = 17'(pt[m]) + 17'(dt4_reg[m]);
            sum16[m] = (sum17[m] > 17'sd32767) ? 16'sd32767 :
                       (sum17[m] < -17'sd32768) ? -16'sd32768 : 16'(sum17[m]);
            mv[m] = 18'(thr4_reg) + 18'(sum16[m]);
            if (!arm4_reg || mv[m] < 0)
                mot[m] = '0;
            else if (mv[m] > lim)
                mot[m] = lim[10:0];
            else
                mot[m] = mv[m][10:0];
        end
        res_next.motor_0 = mot[0];
        res_next.motor_1 = mot[1];
        res_next.motor_2 = mot[2];
        res_next.motor_3 = mot[3];
        res_next.active  = arm4_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign done = v5_reg;
    assign result = res_reg;

    `ASSERT_IMPL(a_done_follows_stage4, clk, rst_n, done, $past(v4_reg))
    `ASSERT_IMPL(a_disarmed_zero, clk, rst_n, done && !result.active,
        result.motor_0 == 0 && result.motor_1 == 0 && result.motor_2 == 0
        && result.motor_3 == 0)
    `ASSERT_IMPL(a_motor_bound, clk, rst_n, done,
        result.motor_0 <= 11'd1534 && result.motor_1 <= 11'd1534
        && result.motor_2 <= 11'd1534 && result.motor_3 <= 11'd1534)
    `ASSERT_NEVER(a_never_busy, clk, rst_n, busy)
endmodule

### hw/rtl/qapm_scale_rom.sv
// Scale lookup ROM, filled at elaboration, with a registered read port.
// Depends on qapm_pkg.
module qapm_scale_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic [15:0]              data
);
    import qapm_pkg::*;

    logic [15:0] rom [DEPTH];
    logic [15:0] data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_entry
        localparam logic [15:0] Entry = scale_entry(k, DEPTH);
        assign rom[k] = Entry;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;
endmodule
